// ===== rtl/stms_pkg.sv =====
// Shared types and constants for the sphere triangle midpoint subdivider.
package stms_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned FracBits  = 14;
  localparam int unsigned IndexBits = 16;
  localparam int unsigned SumBits   = 17;
  // Squared length of a 17 bit sum vector, three terms.
  localparam int unsigned SqBits    = 36;
  // Radicand is Q << 28; root fits in 32 bits.
  localparam int unsigned RadBits   = 64;
  localparam int unsigned RootBits  = 32;
  // Dividend is |s| << 28, at most 45 bits.
  localparam int unsigned DvdBits   = 46;
  localparam int unsigned QuoBits   = 46;
  localparam logic [15:0] CountMax  = 16'hFFFF;
  localparam logic [15:0] BaseReset = 16'd4;

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] c_x;
    logic signed [15:0] c_y;
    logic signed [15:0] c_z;
    logic [15:0]        a_index;
    logic [15:0]        b_index;
    logic [15:0]        c_index;
  } tri_in_t;

  typedef struct packed {
    logic               kind;
    logic [15:0]        vertex_index;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
    logic [15:0]        corner_first;
    logic [15:0]        corner_second;
    logic [15:0]        corner_third;
    logic               last;
  } res_out_t;

  // Request from front to back: the edge sums AB, BC and AC plus the index set.
  typedef struct packed {
    logic signed [16:0] s0x, s0y, s0z;
    logic signed [16:0] s1x, s1y, s1z;
    logic signed [16:0] s2x, s2y, s2z;
    logic [15:0]        ia, ib, ic;
    logic [15:0]        n0;
  } edge_req_t;

endpackage

// ===== rtl/sphere_triangle_midpoint_subdivider.sv =====
// Per edge the back end runs 3 square steps, 32 root steps and three divides.
// The back end handles one triangle at a time; meanwhile the front end and a
// two-entry queue take up to three more triangles.
// Reset clears the triangle count, the queue and all valid flags;
// the base register returns to 4.
module sphere_triangle_midpoint_subdivider import stms_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  tri_in_t  tri_i,
  output logic     empty,
  input  logic     pop,
  output res_out_t res_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] base_q;
  logic        f_valid, q_ready, b_valid, b_ready;
  edge_req_t   f_req, b_req;

  assign cfg_ready_o = 1'b1;

  // Base index register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) base_q <= BaseReset;
    else if (cfg_valid_i) base_q <= cfg_data_i;
  end

  stms_front u_front (
    .clk_i, .rst_ni, .base_i(base_q), .push_i(push), .tri_i,
    .full_o(full), .req_valid_o(f_valid), .req_o(f_req), .req_ready_i(q_ready)
  );

  stms_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_valid), .in_i(f_req), .in_ready_o(q_ready),
    .out_valid_o(b_valid), .out_o(b_req), .out_ready_i(b_ready)
  );

  stms_back u_back (
    .clk_i, .rst_ni, .req_valid_i(b_valid), .req_i(b_req), .req_ready_o(b_ready),
    .empty_o(empty), .res_o, .pop_i(pop)
  );

endmodule

// ===== rtl/stms_front.sv =====
// Front end: accepts triangles, forms edge sums and new vertex indices.
module stms_front import stms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] base_i,
  input  logic        push_i,
  input  tri_in_t     tri_i,
  output logic        full_o,
  output logic        req_valid_o,
  output edge_req_t   req_o,
  input  logic        req_ready_i
);

  logic        valid_q;
  edge_req_t   req_q;
  logic [15:0] count_q;
  logic        take;

  assign full_o      = valid_q && !req_ready_i;
  assign take        = push_i && !full_o;
  assign req_valid_o = valid_q;
  assign req_o       = req_q;

  // Hold one request; refill as soon as the queue takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= '0;
    end else begin
      if (take) begin
        valid_q <= 1'b1;
        if (count_q != CountMax) count_q <= count_q + 16'd1;
      end else if (req_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Edge sums AB, BC, AC and first new index.
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q.s0x <= 17'(tri_i.a_x) + 17'(tri_i.b_x);
      req_q.s0y <= 17'(tri_i.a_y) + 17'(tri_i.b_y);
      req_q.s0z <= 17'(tri_i.a_z) + 17'(tri_i.b_z);
      req_q.s1x <= 17'(tri_i.b_x) + 17'(tri_i.c_x);
      req_q.s1y <= 17'(tri_i.b_y) + 17'(tri_i.c_y);
      req_q.s1z <= 17'(tri_i.b_z) + 17'(tri_i.c_z);
      req_q.s2x <= 17'(tri_i.a_x) + 17'(tri_i.c_x);
      req_q.s2y <= 17'(tri_i.a_y) + 17'(tri_i.c_y);
      req_q.s2z <= 17'(tri_i.a_z) + 17'(tri_i.c_z);
      req_q.ia  <= tri_i.a_index;
      req_q.ib  <= tri_i.b_index;
      req_q.ic  <= tri_i.c_index;
      req_q.n0  <= base_i + 16'(count_q * 2'd3);
    end
  end

endmodule

// ===== rtl/stms_queue.sv =====
// Two entry request queue between front and back.
module stms_queue import stms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  edge_req_t in_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output edge_req_t out_o,
  input  logic      out_ready_i
);

  edge_req_t   mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        wr, rd;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o       = mem_q[rp_q];
  assign wr          = in_valid_i && in_ready_o;
  assign rd          = out_valid_o && out_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_i;
  end

endmodule

// ===== rtl/stms_back.sv =====
// Back end: normalizes the edge sums AB, BC and AC and emits the new vertices and sub-triangles.
module stms_back import stms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  edge_req_t req_i,
  output logic      req_ready_o,
  output logic      empty_o,
  output res_out_t  res_o,
  input  logic      pop_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StSqrt = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0]        st_q;
  edge_req_t         r_q;
  logic [1:0]        edge_q;   // edge being normalized
  logic [1:0]        comp_q;   // component in the divider / square step
  logic [5:0]        step_q;
  logic [SqBits-1:0] sq_q;
  logic [RadBits-1:0] rem_q;
  logic [RootBits-1:0] root_q;
  logic [DvdBits-1:0] drem_q;
  logic [QuoBits-1:0] quo_q;
  logic [15:0]       mid_q [3][3];
  logic [2:0]        slot_q;
  logic              out_valid_q;
  res_out_t          out_q;

  logic signed [16:0] s_cur;
  logic [16:0]        mag;
  logic [33:0]        mag_sq;
  logic [RadBits-1:0] sr_trial;
  logic [QuoBits-1:0] q_round;
  logic [15:0]        comp_res;
  logic               emit_ok;

  // Current component of the current edge.
  always_comb begin
    case ({edge_q, comp_q})
      4'b0000: s_cur = r_q.s0x;
      4'b0001: s_cur = r_q.s0y;
      4'b0010: s_cur = r_q.s0z;
      4'b0100: s_cur = r_q.s1x;
      4'b0101: s_cur = r_q.s1y;
      4'b0110: s_cur = r_q.s1z;
      4'b1000: s_cur = r_q.s2x;
      4'b1001: s_cur = r_q.s2y;
      default: s_cur = r_q.s2z;
    endcase
  end
  assign mag    = s_cur[16] ? 17'(-s_cur) : 17'(s_cur);
  assign mag_sq = mag * mag;

  // Digit-by-digit root trial: (root<<2 | 1) << (2*step) over remainder.
  always_comb begin
    sr_trial = ({32'd0, root_q} << 2 | 64'd1) << {step_q[4:0], 1'b0};
  end

  // Rounded, saturated, signed component.
  always_comb begin
    q_round  = quo_q;
    if (q_round > QuoBits'(16384)) q_round = QuoBits'(16384);
    comp_res = s_cur[16] ? 16'(-q_round[15:0]) : q_round[15:0];
  end

  assign emit_ok     = !out_valid_q || pop_i;
  assign req_ready_o = st_q == StIdle;
  assign empty_o     = !out_valid_q;
  assign res_o       = out_q;

  // Divider: dividend |s|<<28 + root/2, shift-subtract one bit a cycle.
  logic [RootBits:0]  dpart;
  logic [RootBits+1:0] dsub;
  logic [RootBits:0]  dhi_q;
  assign dpart = {dhi_q[RootBits-1:0], drem_q[DvdBits-1]};
  assign dsub  = {1'b0, dpart} - {2'b0, root_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      out_valid_q <= 1'b0;
      edge_q      <= '0;
      comp_q      <= '0;
      step_q      <= '0;
      slot_q      <= '0;
    end else begin
      if (pop_i && out_valid_q) out_valid_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (req_valid_i) begin
            st_q   <= StSq;
            edge_q <= '0;
            comp_q <= '0;
            sq_q   <= '0;
          end
        end
        // Accumulate squares, one component a cycle.
        StSq: begin
          sq_q <= sq_q + SqBits'(mag_sq);
          if (comp_q == 2'd2) begin
            comp_q <= '0;
            st_q   <= StSqrt;
            step_q <= 6'd31;
            root_q <= '0;
            rem_q  <= {sq_q + SqBits'(mag_sq), 28'd0};
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        // Integer square root, one result bit a cycle.
        StSqrt: begin
          if (rem_q >= sr_trial) begin
            rem_q  <= rem_q - sr_trial;
            root_q <= (root_q << 1) | 32'd1;
          end else begin
            root_q <= root_q << 1;
          end
          if (step_q == 6'd0) begin
            st_q <= StDiv;
            comp_q <= '0;
            step_q <= 6'(DvdBits);
            dhi_q  <= '0;
          end else begin
            step_q <= step_q - 6'd1;
          end
        end
        // One quotient bit a cycle; step counts down the dividend bits.
        StDiv: begin
          if (step_q == 6'(DvdBits)) begin
            drem_q <= DvdBits'({mag, 28'd0}) + DvdBits'(root_q >> 1);
            quo_q  <= '0;
            dhi_q  <= '0;
            step_q <= step_q - 6'd1;
            if (sq_q == '0) begin
              quo_q  <= '0;
              step_q <= 6'd63;
            end
          end else if (step_q == 6'd63) begin
            // Zero sum: all components zero.
            mid_q[edge_q][comp_q] <= '0;
            if (comp_q == 2'd2) begin
              comp_q <= '0;
              if (edge_q == 2'd2) begin
                st_q <= StEmit; slot_q <= '0;
              end else begin
                edge_q <= edge_q + 2'd1; st_q <= StSq; sq_q <= '0;
              end
            end else begin
              comp_q <= comp_q + 2'd1; step_q <= 6'(DvdBits);
            end
          end else begin
            drem_q <= drem_q << 1;
            if (!dsub[RootBits+1]) begin
              dhi_q <= dsub[RootBits:0];
              quo_q <= (quo_q << 1) | QuoBits'(1);
            end else begin
              dhi_q <= dpart;
              quo_q <= quo_q << 1;
            end
            if (step_q == 6'd0) begin
              step_q <= 6'd62;
            end else begin
              step_q <= step_q - 6'd1;
            end
          end
          if (step_q == 6'd62) begin
            mid_q[edge_q][comp_q] <= comp_res;
            step_q <= 6'(DvdBits);
            if (comp_q == 2'd2) begin
              comp_q <= '0;
              if (edge_q == 2'd2) begin
                st_q <= StEmit; slot_q <= '0;
              end else begin
                edge_q <= edge_q + 2'd1; st_q <= StSq; sq_q <= '0;
              end
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end
        end
        // Seven results into the output register.
        StEmit: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            slot_q      <= slot_q + 3'd1;
            if (slot_q == 3'd6) st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // Result fields per slot.
  logic [15:0] n0, n1, n2;
  assign n0 = r_q.n0;
  assign n1 = r_q.n0 + 16'd1;
  assign n2 = r_q.n0 + 16'd2;

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && req_valid_i) r_q <= req_i;
    if (st_q == StEmit && emit_ok) begin
      out_q <= '0;
      case (slot_q)
        3'd0: begin
          out_q.vertex_index <= n0;
          out_q.vertex_x <= mid_q[0][0];
          out_q.vertex_y <= mid_q[0][1];
          out_q.vertex_z <= mid_q[0][2];
        end
        3'd1: begin
          out_q.vertex_index <= n1;
          out_q.vertex_x <= mid_q[1][0];
          out_q.vertex_y <= mid_q[1][1];
          out_q.vertex_z <= mid_q[1][2];
        end
        3'd2: begin
          out_q.vertex_index <= n2;
          out_q.vertex_x <= mid_q[2][0];
          out_q.vertex_y <= mid_q[2][1];
          out_q.vertex_z <= mid_q[2][2];
        end
        3'd3: begin
          out_q.kind <= 1'b1;
          out_q.corner_first <= r_q.ia;
          out_q.corner_second <= n0;
          out_q.corner_third <= n2;
        end
        3'd4: begin
          out_q.kind <= 1'b1;
          out_q.corner_first <= n0;
          out_q.corner_second <= r_q.ib;
          out_q.corner_third <= n1;
        end
        3'd5: begin
          out_q.kind <= 1'b1;
          out_q.corner_first <= n2;
          out_q.corner_second <= n0;
          out_q.corner_third <= n1;
        end
        default: begin
          out_q.kind <= 1'b1;
          out_q.corner_first <= r_q.ic;
          out_q.corner_second <= n2;
          out_q.corner_third <= n1;
          out_q.last <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== sim/sphere_triangle_midpoint_subdivider_test.sv =====
// Self-checking testbench for the sphere triangle midpoint subdivider.
module sphere_triangle_midpoint_subdivider_test import stms_pkg::*;;

  localparam int unsigned DrainCycles = 700;
  localparam int unsigned CycleLimit  = 2000000;

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  logic     full;
  tri_in_t  tri_i;
  logic     empty;
  logic     pop;
  res_out_t res_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [15:0] cfg_data_i;

  // Predictor state
  logic [15:0] base_index;
  logic [15:0] tri_count;
  res_out_t    pending_results[$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  sphere_triangle_midpoint_subdivider i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .tri_i       (tri_i),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Normalized sum of two points, packed as {x, y, z}
  function automatic logic [47:0] edge_midpoint(input logic signed [15:0] px, py, pz,
                                                input logic signed [15:0] qx, qy, qz);
    longint            sum[3];
    longint unsigned   mag[3];
    longint unsigned   sq;
    longint unsigned   rad;
    longint unsigned   root;
    longint unsigned   bit_pos;
    longint unsigned   quo;
    logic [15:0]       comp[3];
    sum[0] = longint'(px) + longint'(qx);
    sum[1] = longint'(py) + longint'(qy);
    sum[2] = longint'(pz) + longint'(qz);
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (sum[i] < 0) ? longint'(-sum[i]) : longint'(sum[i]);
      sq += mag[i] * mag[i];
    end
    if (sq == 0) return 48'd0;
    // Bit-serial integer square root of Q << 28
    rad = sq << 28;
    root = 0;
    bit_pos = 64'd1 << 62;
    while (bit_pos > rad) bit_pos >>= 2;
    while (bit_pos != 0) begin
      if (rad >= root + bit_pos) begin
        rad -= root + bit_pos;
        root = (root >> 1) + bit_pos;
      end else begin
        root >>= 1;
      end
      bit_pos >>= 2;
    end
    // Rounded divide, saturate at +-1.0, sign last
    for (int i = 0; i < 3; i++) begin
      quo = ((mag[i] << 28) + (root >> 1)) / root;
      if (quo > (64'd1 << FracBits)) quo = 64'd1 << FracBits;
      comp[i] = (sum[i] < 0) ? 16'(-quo) : 16'(quo);
    end
    return {comp[0], comp[1], comp[2]};
  endfunction

  // Expected seven results of one triangle
  task automatic predict_subdivision(input tri_in_t t);
    logic [47:0] v[3];
    logic [15:0] n0, n1, n2;
    res_out_t    r;
    v[0] = edge_midpoint(t.a_x, t.a_y, t.a_z, t.b_x, t.b_y, t.b_z);
    v[1] = edge_midpoint(t.b_x, t.b_y, t.b_z, t.c_x, t.c_y, t.c_z);
    v[2] = edge_midpoint(t.a_x, t.a_y, t.a_z, t.c_x, t.c_y, t.c_z);
    n0 = base_index + 16'(3 * tri_count);
    n1 = n0 + 16'd1;
    n2 = n0 + 16'd2;
    for (int i = 0; i < 3; i++) begin
      r = '0;
      r.vertex_index = n0 + 16'(i);
      {r.vertex_x, r.vertex_y, r.vertex_z} = v[i];
      pending_results.push_back(r);
    end
    r = '0; r.kind = 1'b1;
    r.corner_first = t.a_index; r.corner_second = n0; r.corner_third = n2;
    pending_results.push_back(r);
    r.corner_first = n0; r.corner_second = t.b_index; r.corner_third = n1;
    pending_results.push_back(r);
    r.corner_first = n2; r.corner_second = n0; r.corner_third = n1;
    pending_results.push_back(r);
    r.corner_first = t.c_index; r.corner_second = n2; r.corner_third = n1;
    r.last = 1'b1;
    pending_results.push_back(r);
    if (tri_count != CountMax) tri_count++;
  endtask

  // Result check and receiver stalls; values are pre-edge here
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        error_count++;
      end else begin
        if (pending_results[0] !== res_o) begin
          $display("%0t: mismatch expected %h actual %h", $time, pending_results[0], res_o);
          error_count++;
        end
        void'(pending_results.pop_front());
      end
    end
    pop <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Send one triangle request; push stays high on return
  task automatic send_triangle(input tri_in_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push  <= 1'b1;
    tri_i <= t;
    do @(posedge clk_i); while (full);
    predict_subdivision(t);
  endtask

  // Stop sending and wait for every expected result
  task automatic drain_block();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Base register write, block idle
  task automatic write_base(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    base_index = value;
  endtask

  function automatic logic [15:0] rand_coord();
    // Mostly on-range values, some raw patterns
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(32768) - 16384);
  endfunction

  function automatic tri_in_t rand_triangle();
    tri_in_t t;
    t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
    t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
    t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
    // Opposite corners now and then, for zero sums
    if ($urandom_range(9) == 0) begin
      t.b_x = -t.a_x; t.b_y = -t.a_y; t.b_z = -t.a_z;
    end
    t.a_index = 16'($urandom);
    t.b_index = 16'($urandom);
    t.c_index = 16'($urandom);
    return t;
  endfunction

  function automatic tri_in_t make_triangle(input logic signed [15:0] ax, ay, az,
                                            input logic signed [15:0] bx, by, bz,
                                            input logic signed [15:0] cx, cy, cz);
    tri_in_t t;
    t = '{ax, ay, az, bx, by, bz, cx, cy, cz, 16'd0, 16'd1, 16'd2};
    return t;
  endfunction

  // Axis points at +-1.0 and other unit-range corners
  task automatic test_axis_extremes();
    tri_in_t t;
    send_triangle(make_triangle(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_triangle(make_triangle(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    t = make_triangle(16384, 16384, 16384, -16384, 16384, -16384, 1, -1, 0);
    t.a_index = 16'hFFFF; t.b_index = 16'h0000; t.c_index = 16'h8000;
    send_triangle(t);
    send_triangle(make_triangle(1, 0, 0, 0, 1, 0, 0, 0, -1));
    drain_block();
  endtask

  // Zero-length sums on one, on two and on all edges
  task automatic test_zero_sum();
    send_triangle(make_triangle(16384, 0, 0, -16384, 0, 0, 0, 16384, 0));
    drain_block();
    // Pause until all results came, then the next request
    send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain_block();
    send_triangle(make_triangle(100, -200, 300, -100, 200, -300, 100, -200, 300));
    drain_block();
  endtask

  // Off-sphere patterns, saturated components
  task automatic test_off_sphere();
    send_triangle(make_triangle(-32768, -32768, -32768, -32768, -32768, -32768,
                                32767, 32767, 32767));
    send_triangle(make_triangle(32767, 0, 0, 32767, 0, 0, -32768, 0, 0));
    send_triangle(make_triangle(-32768, 32767, 1, 16'sh5555, 16'shAAAA, 0, 0, 0, 1));
    drain_block();
  endtask

  // New-vertex index wrap at the top of the index range
  task automatic test_index_wrap();
    write_base(16'hFFFF);
    send_triangle(rand_triangle());
    drain_block();
    write_base(16'hFFFD);
    send_triangle(rand_triangle());
    send_triangle(rand_triangle());
    drain_block();
  endtask

  task automatic test_random_phase(input int unsigned count, input int unsigned idle_pct,
                                   input int unsigned stall_pct, input logic [15:0] base);
    drain_block();
    write_base(base);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_triangle(rand_triangle());
    drain_block();
  endtask

  initial begin
    rst_ni             = 1'b0;
    push               = 1'b0;
    pop                = 1'b0;
    tri_i              = '0;
    cfg_valid_i        = 1'b0;
    cfg_data_i         = '0;
    base_index         = BaseReset;
    tri_count          = '0;
    error_count        = 0;
    cycle_count        = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_axis_extremes();
    test_zero_sum();
    test_off_sphere();
    test_index_wrap();
    test_random_phase(100, 0, 0, 16'd0);
    test_random_phase(90, 77, 0, 16'($urandom));
    test_random_phase(90, 0, 77, 16'hFFF0);
    test_random_phase(90, 15, 15, 16'd12);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
